// ===== hw/rtl/fsl_pkg.sv =====
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared types, register codes and threshold constants of the four-sensor
// safety lockout.
// ----------------------------------------------------------------------------
`default_nettype none

package fsl_pkg;

  // Widths of the sample fields
  localparam int unsigned SmallW   = 8;
  localparam int unsigned CurrentW = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BeepW    = 4;
  localparam int unsigned MsgW     = 4;

  // Water depth code for a missing reading
  localparam logic [SmallW-1:0] NoWaterReading = 8'hFF;

  // Fixed clear thresholds (hysteresis release points)
  localparam logic [SmallW-1:0]   WaterClearLevel   = 8'd15;
  localparam logic [SmallW-1:0]   SoilClearLevel    = 8'd70;
  localparam logic [CurrentW-1:0] CurrentClearLevel = 16'd1200;
  localparam logic [SmallW-1:0]   TempClearLevel    = 8'd45;

  // Register reset values
  localparam logic [SmallW-1:0]   WaterActionRst   = 8'd5;
  localparam logic [SmallW-1:0]   WaterWarnRst     = 8'd10;
  localparam logic [SmallW-1:0]   SoilActionRst    = 8'd90;
  localparam logic [SmallW-1:0]   SoilWarnRst      = 8'd80;
  localparam logic [CurrentW-1:0] CurrentActionRst = 16'd2000;
  localparam logic [CurrentW-1:0] CurrentWarnRst   = 16'd1500;
  localparam logic [SmallW-1:0]   TempActionRst    = 8'd60;
  localparam logic [SmallW-1:0]   TempWarnRst      = 8'd50;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WATER_ACTION   = 4'd0,
    CFG_WATER_WARN     = 4'd1,
    CFG_SOIL_ACTION    = 4'd2,
    CFG_SOIL_WARN      = 4'd3,
    CFG_CURRENT_ACTION = 4'd4,
    CFG_CURRENT_WARN   = 4'd5,
    CFG_TEMP_ACTION    = 4'd6,
    CFG_TEMP_WARN      = 4'd7
  } cfg_idx_e;

  // Per-sensor level
  typedef enum logic [1:0] {
    LVL_CLEAR  = 2'd0,
    LVL_WARN   = 2'd1,
    LVL_ACTION = 2'd2
  } level_e;

  // Message codes
  typedef enum logic [MsgW-1:0] {
    MSG_NONE          = 4'd0,
    MSG_LOCK_WATER    = 4'd1,
    MSG_LOCK_SOIL     = 4'd2,
    MSG_LOCK_CURRENT  = 4'd3,
    MSG_LOCK_HEAT     = 4'd4,
    MSG_WARN_WATER    = 4'd5,
    MSG_WARN_SOIL     = 4'd6,
    MSG_WARN_CURRENT  = 4'd7,
    MSG_WARN_HEAT     = 4'd8
  } msg_e;

  // Beep mask bit positions
  localparam int unsigned BeepWater   = 0;
  localparam int unsigned BeepSoil    = 1;
  localparam int unsigned BeepCurrent = 2;
  localparam int unsigned BeepTemp    = 3;

  // Thresholds for one sensor, widened to the current width
  typedef struct packed {
    logic [CurrentW-1:0] action;
    logic [CurrentW-1:0] warn;
    logic [CurrentW-1:0] clear;
  } thresh_t;

  // Outcome of one sensor check
  typedef struct packed {
    logic   hit_action;
    logic   hit_warn;
    logic   beep;
    level_e level;
  } lvl_eval_t;

  // Result word
  typedef struct packed {
    logic             pump_cut;
    logic             motor_cut;
    logic             fan_running;
    logic             red_lamp;
    logic             yellow_lamp;
    logic             locked_out;
    logic [BeepW-1:0] warn_beep_mask;
    logic             lockout_beep;
    logic [MsgW-1:0]  message_code;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fsl_ifs.sv =====
// ----------------------------------------------------------------------------
// fsl channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

// Sample set channel
interface fsl_smp_if;
  logic                          valid;
  logic                          ready;
  logic [fsl_pkg::SmallW-1:0]    soil_moisture;
  logic [fsl_pkg::SmallW-1:0]    temperature;
  logic [fsl_pkg::CurrentW-1:0]  motor_current;
  logic [fsl_pkg::SmallW-1:0]    water_depth;

  modport source (output valid, soil_moisture, temperature, motor_current, water_depth,
                  input ready);
  modport sink   (input valid, soil_moisture, temperature, motor_current, water_depth,
                  output ready);
endinterface

// Result channel
interface fsl_res_if;
  logic                       valid;
  logic                       ready;
  logic                       pump_cut;
  logic                       motor_cut;
  logic                       fan_running;
  logic                       red_lamp;
  logic                       yellow_lamp;
  logic                       locked_out;
  logic [fsl_pkg::BeepW-1:0]  warn_beep_mask;
  logic                       lockout_beep;
  logic [fsl_pkg::MsgW-1:0]   message_code;

  modport source (output valid, pump_cut, motor_cut, fan_running, red_lamp, yellow_lamp,
                         locked_out, warn_beep_mask, lockout_beep, message_code,
                  input ready);
  modport sink   (input valid, pump_cut, motor_cut, fan_running, red_lamp, yellow_lamp,
                        locked_out, warn_beep_mask, lockout_beep, message_code,
                  output ready);
endinterface

// Configuration write channel
interface fsl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fsl_pkg::CfgIdxW-1:0]   index;
  logic [fsl_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fsl_level.sv =====
// ----------------------------------------------------------------------------
// fsl_level
// One sensor's three-band check with hysteresis: action, warn, else clear,
// else hold. Low-trip sensors compare downward, the others upward.
// ----------------------------------------------------------------------------
`default_nettype none

module fsl_level (
  input  wire logic [fsl_pkg::CurrentW-1:0] reading_i,
  input  wire fsl_pkg::thresh_t             thresh_i,
  input  wire logic                         trip_low_i,
  input  wire logic                         enable_i,
  input  wire fsl_pkg::level_e              level_i,
  output fsl_pkg::lvl_eval_t                eval_o
);
  import fsl_pkg::*;

  logic at_action;
  logic at_warn;
  logic at_clear;

  // Band compares
  always_comb begin
    if (trip_low_i) begin
      at_action = reading_i <= thresh_i.action;
      at_warn   = reading_i <= thresh_i.warn;
      at_clear  = reading_i >= thresh_i.clear;
    end else begin
      at_action = reading_i >= thresh_i.action;
      at_warn   = reading_i >= thresh_i.warn;
      at_clear  = reading_i <= thresh_i.clear;
    end
  end

  // Priority: action, then warn, then clear; otherwise hold
  always_comb begin
    eval_o.hit_action = 1'b0;
    eval_o.hit_warn   = 1'b0;
    eval_o.beep       = 1'b0;
    eval_o.level      = level_i;
    if (enable_i) begin
      if (at_action) begin
        eval_o.hit_action = 1'b1;
        eval_o.level      = LVL_ACTION;
      end else if (at_warn) begin
        eval_o.hit_warn = 1'b1;
        eval_o.beep     = (level_i == LVL_CLEAR);
        eval_o.level    = LVL_WARN;
      end else if (at_clear) begin
        eval_o.level = LVL_CLEAR;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/four_sensor_safety_lockout.sv =====
// ----------------------------------------------------------------------------
// four_sensor_safety_lockout
// A sample set is held in the input register, then moves to the result register.
// Throughput: one sample set per cycle while out_o.ready is high; input and
// result registers let a new set enter while the previous result waits.
// Reset: levels clear, lockout, fan and lamps off, thresholds at defaults.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module four_sensor_safety_lockout (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fsl_smp_if.sink   in_i,
  fsl_res_if.source out_o,
  fsl_cfg_if.sink   cfg_i
);
  import fsl_pkg::*;

  // Threshold registers
  logic [SmallW-1:0]   water_action_q, water_warn_q;
  logic [SmallW-1:0]   soil_action_q, soil_warn_q;
  logic [CurrentW-1:0] current_action_q, current_warn_q;
  logic [SmallW-1:0]   temp_action_q, temp_warn_q;

  // Input stage
  logic                in_valid_q;
  logic [SmallW-1:0]   soil_q, temp_q, water_q;
  logic [CurrentW-1:0] current_q;

  // Sensor and lamp state
  level_e water_lvl_q, soil_lvl_q, current_lvl_q, temp_lvl_q;
  logic   lockout_q, fan_q, red_q, yellow_q;
  logic   lockout_d, fan_d, red_d, yellow_d;

  // Result stage
  logic    out_valid_q;
  result_t res_q, res_d;

  logic advance;

  lvl_eval_t water_ev, soil_ev, current_ev, temp_ev;
  thresh_t   water_th, soil_th, current_th, temp_th;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      water_action_q   <= WaterActionRst;
      water_warn_q     <= WaterWarnRst;
      soil_action_q    <= SoilActionRst;
      soil_warn_q      <= SoilWarnRst;
      current_action_q <= CurrentActionRst;
      current_warn_q   <= CurrentWarnRst;
      temp_action_q    <= TempActionRst;
      temp_warn_q      <= TempWarnRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_WATER_ACTION:   water_action_q   <= cfg_i.data[SmallW-1:0];
        CFG_WATER_WARN:     water_warn_q     <= cfg_i.data[SmallW-1:0];
        CFG_SOIL_ACTION:    soil_action_q    <= cfg_i.data[SmallW-1:0];
        CFG_SOIL_WARN:      soil_warn_q      <= cfg_i.data[SmallW-1:0];
        CFG_CURRENT_ACTION: current_action_q <= cfg_i.data[CurrentW-1:0];
        CFG_CURRENT_WARN:   current_warn_q   <= cfg_i.data[CurrentW-1:0];
        CFG_TEMP_ACTION:    temp_action_q    <= cfg_i.data[SmallW-1:0];
        CFG_TEMP_WARN:      temp_warn_q      <= cfg_i.data[SmallW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input word moves to the result register when it is free
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      soil_q    <= in_i.soil_moisture;
      temp_q    <= in_i.temperature;
      current_q <= in_i.motor_current;
      water_q   <= in_i.water_depth;
    end
  end

  // Sensor checks
  assign water_th   = '{action: CurrentW'(water_action_q), warn: CurrentW'(water_warn_q),
                        clear: CurrentW'(WaterClearLevel)};
  assign soil_th    = '{action: CurrentW'(soil_action_q), warn: CurrentW'(soil_warn_q),
                        clear: CurrentW'(SoilClearLevel)};
  assign current_th = '{action: current_action_q, warn: current_warn_q,
                        clear: CurrentClearLevel};
  assign temp_th    = '{action: CurrentW'(temp_action_q), warn: CurrentW'(temp_warn_q),
                        clear: CurrentW'(TempClearLevel)};

  fsl_level u_water (
    .reading_i  (CurrentW'(water_q)),
    .thresh_i   (water_th),
    .trip_low_i (1'b1),
    .enable_i   (water_q != NoWaterReading),
    .level_i    (water_lvl_q),
    .eval_o     (water_ev)
  );

  fsl_level u_soil (
    .reading_i  (CurrentW'(soil_q)),
    .thresh_i   (soil_th),
    .trip_low_i (1'b0),
    .enable_i   (1'b1),
    .level_i    (soil_lvl_q),
    .eval_o     (soil_ev)
  );

  fsl_level u_current (
    .reading_i  (current_q),
    .thresh_i   (current_th),
    .trip_low_i (1'b0),
    .enable_i   (1'b1),
    .level_i    (current_lvl_q),
    .eval_o     (current_ev)
  );

  fsl_level u_temp (
    .reading_i  (CurrentW'(temp_q)),
    .thresh_i   (temp_th),
    .trip_low_i (1'b0),
    .enable_i   (1'b1),
    .level_i    (temp_lvl_q),
    .eval_o     (temp_ev)
  );

  // Lockout, lamps, fan and result word
  always_comb begin
    logic action;
    logic any_level;
    logic fan_pre;

    action = water_ev.hit_action | soil_ev.hit_action |
             current_ev.hit_action | temp_ev.hit_action;
    any_level = (water_ev.level != LVL_CLEAR) || (soil_ev.level != LVL_CLEAR) ||
                (current_ev.level != LVL_CLEAR) || (temp_ev.level != LVL_CLEAR);
    fan_pre = fan_q | temp_ev.hit_action | temp_ev.hit_warn;

    lockout_d = lockout_q;
    fan_d     = fan_pre;
    red_d     = red_q;
    yellow_d  = yellow_q;
    if (action) begin
      lockout_d = 1'b1;
      red_d     = 1'b1;
      yellow_d  = 1'b0;
    end else if (lockout_q) begin
      if (!any_level) begin
        lockout_d = 1'b0;
        fan_d     = 1'b0;
        red_d     = 1'b0;
      end
    end else if (any_level) begin
      yellow_d = 1'b1;
    end else begin
      yellow_d = 1'b0;
      fan_d    = 1'b0;
    end

    res_d.pump_cut       = action;
    res_d.motor_cut      = current_ev.hit_action | temp_ev.hit_action;
    res_d.fan_running    = fan_d;
    res_d.red_lamp       = red_d;
    res_d.yellow_lamp    = yellow_d;
    res_d.locked_out     = lockout_d;
    res_d.warn_beep_mask = '0;
    res_d.warn_beep_mask[BeepWater]   = water_ev.beep;
    res_d.warn_beep_mask[BeepSoil]    = soil_ev.beep;
    res_d.warn_beep_mask[BeepCurrent] = current_ev.beep;
    res_d.warn_beep_mask[BeepTemp]    = temp_ev.beep;
    res_d.lockout_beep   = action;

    // Last sensor in check order with a message wins
    if (temp_ev.hit_action)         res_d.message_code = MSG_LOCK_HEAT;
    else if (temp_ev.hit_warn)      res_d.message_code = MSG_WARN_HEAT;
    else if (current_ev.hit_action) res_d.message_code = MSG_LOCK_CURRENT;
    else if (current_ev.hit_warn)   res_d.message_code = MSG_WARN_CURRENT;
    else if (soil_ev.hit_action)    res_d.message_code = MSG_LOCK_SOIL;
    else if (soil_ev.hit_warn)      res_d.message_code = MSG_WARN_SOIL;
    else if (water_ev.hit_action)   res_d.message_code = MSG_LOCK_WATER;
    else if (water_ev.hit_warn)     res_d.message_code = MSG_WARN_WATER;
    else                            res_d.message_code = MSG_NONE;
  end

  // State commits as the word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      water_lvl_q   <= LVL_CLEAR;
      soil_lvl_q    <= LVL_CLEAR;
      current_lvl_q <= LVL_CLEAR;
      temp_lvl_q    <= LVL_CLEAR;
      lockout_q     <= 1'b0;
      fan_q         <= 1'b0;
      red_q         <= 1'b0;
      yellow_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (advance) begin
        water_lvl_q   <= water_ev.level;
        soil_lvl_q    <= soil_ev.level;
        current_lvl_q <= current_ev.level;
        temp_lvl_q    <= temp_ev.level;
        lockout_q     <= lockout_d;
        fan_q         <= fan_d;
        red_q         <= red_d;
        yellow_q      <= yellow_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Result port
  assign out_o.valid          = out_valid_q;
  assign out_o.pump_cut       = res_q.pump_cut;
  assign out_o.motor_cut      = res_q.motor_cut;
  assign out_o.fan_running    = res_q.fan_running;
  assign out_o.red_lamp       = res_q.red_lamp;
  assign out_o.yellow_lamp    = res_q.yellow_lamp;
  assign out_o.locked_out     = res_q.locked_out;
  assign out_o.warn_beep_mask = res_q.warn_beep_mask;
  assign out_o.lockout_beep   = res_q.lockout_beep;
  assign out_o.message_code   = res_q.message_code;

endmodule

`default_nettype wire
